// ===== hw/rtl/lru_block_cache_tags_core_macros.svh =====
// Assertion macros used by the cache tag store controller.
`ifndef LRU_BLOCK_CACHE_TAGS_CORE_MACROS_SVH
`define LRU_BLOCK_CACHE_TAGS_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbct assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LBCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbct assertion failed");

`endif

// ===== hw/rtl/lbct_pkg.sv =====
package lbct_pkg;

    localparam int LINES       = 64;
    localparam int DRUM_BITS   = 4;
    localparam int BLOCK_BITS  = 8;
    localparam int HANDLE_BITS = 16;
    localparam int LINE_BITS   = $clog2(LINES);
    localparam int CNT_BITS    = $clog2(LINES + 1);
    localparam int CFG_BITS    = 7;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef struct packed {
        logic                   cmd;
        logic [DRUM_BITS-1:0]   drum_id;
        logic [BLOCK_BITS-1:0]  block_id;
        logic [HANDLE_BITS-1:0] line_handle;
    } req_item_t;

    typedef struct packed {
        logic                   hit;
        logic [HANDLE_BITS-1:0] found_handle;
        logic [LINE_BITS-1:0]   slot;
        logic                   evicted;
        logic [HANDLE_BITS-1:0] evicted_handle;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the request beat
        logic look;    // search the tags and read the handle store
        logic commit;  // update the store and load the response register
        logic clear;   // configuration write: set the line count and empty the store
    } ctrl_cmd_t;

endpackage

// ===== hw/rtl/lru_block_cache_tags_core.sv =====
// Fully associative tag store with least recently used replacement.
// The request channel (req_valid, req_ready, req) carries one command per
// beat: a lookup of a drum and block key, or an insert of that key with a
// line handle. The response channel (rsp_valid, rsp_ready, rsp) returns
// exactly one beat per request, in order.
// Each request goes through a look step, which compares the key against all
// tag cells in parallel and reads the handle store, and then a commit step,
// which updates the recency ranks and loads the response register. The
// block does not take a new request while the previous one is in its look
// step. A new request is taken in the same cycle that the previous one
// commits, as long as the response register is empty or being drained.
// When the receiver stalls, one response waits in the output register and
// the next request finishes its search, then holds until that beat leaves.
// Reset empties the store at once (valid bits and ranks are flip-flops) and
// sets the number of lines in use to the full size. A write on cfg_we sets
// the number of lines in use and empties the store the same way; it is to
// be done only while no request is in flight.
module lru_block_cache_tags_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  lbct_pkg::req_item_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output lbct_pkg::rsp_item_t           rsp,
    input  logic                          cfg_we,
    input  logic [lbct_pkg::CFG_BITS-1:0] cfg_data
);

    // Commands from the sequencer to the tag datapath.
    lbct_pkg::ctrl_cmd_t cmd;

    lbct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cfg_we    (cfg_we),
        .cmd       (cmd)
    );

    // The datapath holds the tag cells, valid bits, ranks and handle store.
    lbct_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule

// ===== hw/rtl/lbct_handle_ram.sv =====
module lbct_handle_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lbct_ctrl.sv =====
`include "lru_block_cache_tags_core_macros.svh"

module lbct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic                cfg_we,
    output lbct_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       can_commit;
    logic       load;

    // The response register is free when empty or being drained this cycle.
    assign can_commit = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == S_IDLE) || ((state_reg == S_UPD) && can_commit);
    assign load       = req_valid && req_ready;

    assign cmd.load   = load;
    assign cmd.look   = (state_reg == S_LOOK);
    assign cmd.commit = (state_reg == S_UPD) && can_commit;
    assign cmd.clear  = cfg_we;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (load)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (can_commit)
                begin
                    state_next = load ? S_LOOK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    `LBCT_ASSERT_NEXT(a_load_to_look, clk, rst_n, load, state_reg == S_LOOK)
    `LBCT_ASSERT_NEXT(a_look_to_upd, clk, rst_n, state_reg == S_LOOK, state_reg == S_UPD)
    `LBCT_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, rsp_valid_reg)
    `LBCT_ASSERT_SAME(a_rise_after_commit, clk, rst_n, $rose(rsp_valid_reg), $past(cmd.commit))

endmodule

// ===== hw/rtl/lbct_dp.sv =====
module lbct_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lbct_pkg::ctrl_cmd_t                  cmd,
    input  lbct_pkg::req_item_t                  req,
    input  logic [lbct_pkg::CFG_BITS-1:0]        cfg_data,
    output lbct_pkg::rsp_item_t                  rsp
);

    localparam int LINES = lbct_pkg::LINES;
    localparam int LB    = lbct_pkg::LINE_BITS;
    localparam int CB    = lbct_pkg::CNT_BITS;

    function automatic logic [LB-1:0] first_set(input logic [LINES-1:0] v);
        logic [LB-1:0] idx;
        idx = '0;
        for (int i = LINES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = LB'(i);
            end
        end
        return idx;
    endfunction

    // Control state.
    logic [CB-1:0]    n_reg, n_next;
    logic [LINES-1:0] valid_reg;
    logic [LB-1:0]    rank_reg [LINES];

    // Tag cells and captured request.
    logic [lbct_pkg::DRUM_BITS-1:0]  tag_drum_reg  [LINES];
    logic [lbct_pkg::BLOCK_BITS-1:0] tag_block_reg [LINES];
    lbct_pkg::req_item_t             key_reg;

    // Search results held from the look cycle to the commit cycle.
    logic          hit_reg;
    logic          evict_reg;
    logic          touch_reg;
    logic          tgt_valid_reg;
    logic [LB-1:0] tgt_reg;
    logic [LB-1:0] old_rank_reg;
    lbct_pkg::rsp_item_t rsp_reg;

    logic [LINES-1:0] in_use, match, empty, lru;
    logic [CB-1:0]    n_m1;
    logic [LB-1:0]    hit_idx, empty_idx, lru_idx;
    logic [LB-1:0]    tgt_c, old_rank_c;
    logic             is_insert;
    logic             any_hit, any_empty;
    logic             hit_c, evict_c, touch_c, tgt_valid_c;
    logic [lbct_pkg::HANDLE_BITS-1:0] rdata;
    logic             ram_we;

    assign n_m1      = n_reg - CB'(1);
    assign is_insert = (key_reg.cmd == lbct_pkg::CMD_INSERT);

    always_comb
    begin
        for (int i = 0; i < LINES; i++)
        begin
            in_use[i] = (CB'(i) < n_reg);
            match[i]  = valid_reg[i] && in_use[i] &&
                        (tag_drum_reg[i] == key_reg.drum_id) &&
                        (tag_block_reg[i] == key_reg.block_id);
            empty[i]  = !valid_reg[i] && in_use[i];
            lru[i]    = valid_reg[i] && in_use[i] && (rank_reg[i] == n_m1[LB-1:0]);
        end
    end

    assign hit_idx   = first_set(match);
    assign empty_idx = first_set(empty);
    assign lru_idx   = first_set(lru);
    assign any_hit   = |match;
    assign any_empty = |empty;

    always_comb
    begin
        old_rank_c = '0;
        for (int i = 0; i < LINES; i++)
        begin
            if (LB'(i) == hit_idx)
            begin
                old_rank_c = rank_reg[i];
            end
        end
        hit_c       = 1'b0;
        evict_c     = 1'b0;
        touch_c     = 1'b0;
        tgt_valid_c = 1'b1;
        tgt_c       = hit_idx;
        if (is_insert)
        begin
            touch_c = 1'b1;
            if (any_empty)
            begin
                tgt_c       = empty_idx;
                tgt_valid_c = 1'b0;
            end
            else
            begin
                // A full store ranks its lines 0..n-1; the oldest has rank n-1.
                tgt_c      = lru_idx;
                evict_c    = 1'b1;
                old_rank_c = n_m1[LB-1:0];
            end
        end
        else if (any_hit)
        begin
            hit_c   = 1'b1;
            touch_c = 1'b1;
        end
    end

    always_comb
    begin
        n_next = CB'(cfg_data);
        if (cfg_data == '0)
        begin
            n_next = CB'(1);
        end
        else if (int'(cfg_data) > LINES)
        begin
            n_next = CB'(LINES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= CB'(LINES);
            valid_reg <= '0;
            for (int i = 0; i < LINES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (cmd.clear)
        begin
            n_reg     <= n_next;
            valid_reg <= '0;
            for (int i = 0; i < LINES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (cmd.commit && touch_reg)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                if (LB'(i) == tgt_reg)
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i] && (!tgt_valid_reg || (rank_reg[i] < old_rank_reg)))
                begin
                    rank_reg[i] <= rank_reg[i] + LB'(1);
                end
            end
            if (is_insert)
            begin
                valid_reg[tgt_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= req;
        end
        if (cmd.look)
        begin
            hit_reg       <= hit_c;
            evict_reg     <= evict_c;
            touch_reg     <= touch_c;
            tgt_valid_reg <= tgt_valid_c;
            tgt_reg       <= tgt_c;
            old_rank_reg  <= old_rank_c;
        end
        if (cmd.commit)
        begin
            if (is_insert)
            begin
                tag_drum_reg[tgt_reg]  <= key_reg.drum_id;
                tag_block_reg[tgt_reg] <= key_reg.block_id;
            end
            rsp_reg.hit            <= hit_reg;
            rsp_reg.found_handle   <= hit_reg ? rdata : '0;
            rsp_reg.slot           <= (is_insert || hit_reg) ? tgt_reg : '0;
            rsp_reg.evicted        <= evict_reg;
            rsp_reg.evicted_handle <= evict_reg ? rdata : '0;
        end
    end

    assign ram_we = cmd.commit && is_insert;

    lbct_handle_ram #(
        .DEPTH(LINES),
        .WIDTH(lbct_pkg::HANDLE_BITS)
    ) u_handle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_reg),
        .wdata (key_reg.line_handle),
        .re    (cmd.look),
        .raddr (tgt_c),
        .rdata (rdata)
    );

    assign rsp = rsp_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

// Checks the LRU tag store against a predictor kept in this module. Each request
// beat accepted by the block is run through the predictor, and its answer (or
// the answer typed into the directed table) is queued. Each response beat the
// block hands over is compared, field by field, with the oldest queued answer.
module testbench;

    localparam int   LINES       = lbct_pkg::LINES;
    localparam int   DRUM_BITS   = lbct_pkg::DRUM_BITS;
    localparam int   BLOCK_BITS  = lbct_pkg::BLOCK_BITS;
    localparam int   HANDLE_BITS = lbct_pkg::HANDLE_BITS;
    localparam int   LINE_BITS   = lbct_pkg::LINE_BITS;
    localparam int   CFG_BITS    = lbct_pkg::CFG_BITS;
    localparam logic CMD_LOOKUP  = lbct_pkg::CMD_LOOKUP;
    localparam logic CMD_INSERT  = lbct_pkg::CMD_INSERT;

    // The window between the last response and a setup write.
    localparam int SETTLE_CYCLES = 4;
    // The quiet tail after the last answer, so that a stray extra beat shows up.
    localparam int DRAIN_CYCLES = 8;
    // The limit sits well above the length of the slowest correct run.
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES = 8;
    localparam int BEATS_PER_PHASE = 110;
    localparam int DIRECTED_ROWS = 25;
    // Cap on printed mismatch lines. Every mismatch is still counted.
    localparam int PRINT_CAP = 100;

    typedef enum logic {
        ROW_BEAT,
        ROW_SETUP
    } row_kind_t;

    // One row of the directed table. A setup row writes the line count. A beat
    // row sends one request. When fixed_rsp is set, the answer is typed in
    // here. When it is clear, the predictor gives the answer.
    typedef struct {
        row_kind_t           kind;
        logic [CFG_BITS-1:0] setting;
        lbct_pkg::req_item_t beat;
        logic                fixed_rsp;
        lbct_pkg::rsp_item_t want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    lbct_pkg::req_item_t req = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    lbct_pkg::rsp_item_t rsp;
    logic                cfg_we = 1'b0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    lru_block_cache_tags_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // The predictor's own copy of the tag store. Rank 0 is the most recently
    // used line. Among the valid lines the ranks always run from 0 to count-1.
    logic [CFG_BITS-1:0]    lines_setting = 7'd64;
    logic                   line_live   [LINES];
    logic [DRUM_BITS-1:0]   line_drum   [LINES];
    logic [BLOCK_BITS-1:0]  line_block  [LINES];
    logic [HANDLE_BITS-1:0] line_handle [LINES];
    logic [LINE_BITS-1:0]   line_rank   [LINES];

    lbct_pkg::rsp_item_t pending_answers[$];
    lbct_pkg::rsp_item_t oldest_answer;
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        burst_left = 0;
    int        ready_hold = 0;
    stim_row_t directed_rows [DIRECTED_ROWS];
    logic [CFG_BITS-1:0] phase_settings [PHASES];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Find the number of lines searched and filled. A setting of zero counts
    // as one line. A setting above the store size is held to the full store.
    function automatic int lines_searched();
        if (lines_setting == '0)
            return 1;
        if (int'(lines_setting) > LINES)
            return LINES;
        return int'(lines_setting);
    endfunction

    function automatic void clear_lines();
        for (int i = 0; i < LINES; i++)
        begin
            line_live[i] = 1'b0;
            line_rank[i] = '0;
        end
    endfunction

    // Make a line the most recently used. Each live line that was more recent
    // than it ages by one rank. A line that was empty counts as older than
    // every live line.
    function automatic void promote_line(input int s, input int n);
        int prior;
        prior = line_live[s] ? int'(line_rank[s]) : LINES;
        for (int i = 0; i < n; i++)
        begin
            if (i != s && line_live[i] && int'(line_rank[i]) < prior)
                line_rank[i] = line_rank[i] + 1'b1;
        end
        line_rank[s] = '0;
    endfunction

    function automatic lbct_pkg::rsp_item_t predict_access(input lbct_pkg::req_item_t beat);
        lbct_pkg::rsp_item_t answer;
        int        n;
        int        target;
        answer = '0;
        n = lines_searched();
        if (beat.cmd == CMD_LOOKUP)
        begin
            // When several lines hold the same key, the lowest index answers.
            for (int i = 0; i < n; i++)
            begin
                if (line_live[i] && line_drum[i] == beat.drum_id
                        && line_block[i] == beat.block_id)
                begin
                    answer.hit = 1'b1;
                    answer.found_handle = line_handle[i];
                    answer.slot = LINE_BITS'(i);
                    promote_line(i, n);
                    break;
                end
            end
        end
        else
        begin
            target = n;
            for (int i = 0; i < n; i++)
            begin
                if (!line_live[i])
                begin
                    target = i;
                    break;
                end
            end
            if (target == n)
            begin
                // The store is full, so the line with the highest rank is
                // replaced.
                target = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (line_rank[i] > line_rank[target])
                        target = i;
                end
                answer.evicted = 1'b1;
                answer.evicted_handle = line_handle[target];
            end
            promote_line(target, n);
            line_live[target] = 1'b1;
            line_drum[target] = beat.drum_id;
            line_block[target] = beat.block_id;
            line_handle[target] = beat.line_handle;
            answer.slot = LINE_BITS'(target);
        end
        return answer;
    endfunction

    // Random request. Most lookups aim at a line the store holds, so hits and
    // rank changes are common. Some inserts repeat a key the store holds. The
    // rest use fresh keys over the full field ranges.
    function automatic lbct_pkg::req_item_t random_access();
        lbct_pkg::req_item_t beat;
        int        n;
        int        pick;
        int        idx;
        n = lines_searched();
        pick = $urandom_range(0, 99);
        beat.cmd = (pick < 45) ? CMD_INSERT : CMD_LOOKUP;
        beat.drum_id = DRUM_BITS'($urandom_range(0, 15));
        beat.block_id = BLOCK_BITS'($urandom_range(0, 255));
        beat.line_handle = HANDLE_BITS'($urandom);
        idx = $urandom_range(0, n - 1);
        if (line_live[idx] && ((beat.cmd == CMD_LOOKUP && pick < 80)
                || (beat.cmd == CMD_INSERT && pick < 7)))
        begin
            beat.drum_id = line_drum[idx];
            beat.block_id = line_block[idx];
        end
        return beat;
    endfunction

    // Sender idle time after a beat. Most gaps are zero or short, and a few
    // are long. Now and then a run of beats goes with no gaps at all.
    function automatic int next_gap();
        int pick;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one request beat and hold it until the block takes it. Then
    // queue the expected answer and idle for a while if the gap calls for it.
    // Valid is lowered only when a gap follows, so a back-to-back beat never
    // sees valid drop.
    task automatic issue_beat(input lbct_pkg::req_item_t beat, input logic fixed_rsp,
                              input lbct_pkg::rsp_item_t want);
        lbct_pkg::rsp_item_t predicted;
        int        gap;
        req_valid <= 1'b1;
        req <= beat;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        // The predictor always runs, so its store stays in step even when the
        // answer is typed in.
        predicted = predict_access(beat);
        pending_answers.push_back(fixed_rsp ? want : predicted);
        gap = next_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A setup write empties the store. It is done only with no request in
    // flight. So wait until every answer is back, plus a short margin.
    task automatic write_setting(input logic [CFG_BITS-1:0] value);
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_answers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        lines_setting = value;
        clear_lines();
    endtask

    // Receiver: ready in stretches of random length. There are long runs
    // with no stalls, many short stalls and a few long ones.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    rsp_ready <= 1'b1;
                    ready_hold <= $urandom_range(0, 39);
                end
                4:
                begin
                    rsp_ready <= 1'b0;
                    ready_hold <= $urandom_range(9, 39);
                end
                default:
                begin
                    rsp_ready <= 1'b0;
                    ready_hold <= $urandom_range(0, 2);
                end
            endcase
        end
    end

    // Response checker. Every accepted response beat must match the oldest
    // queued answer in each field. The rsp_ready value read here is the value
    // the block saw at this edge, because the new value lands only after the
    // edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch("response beat with no answer pending", 32'd1, 32'd0);
            end
            else
            begin
                oldest_answer = pending_answers.pop_front();
                if (rsp.hit !== oldest_answer.hit)
                    report_mismatch("hit", 32'(rsp.hit), 32'(oldest_answer.hit));
                if (rsp.found_handle !== oldest_answer.found_handle)
                    report_mismatch("found_handle", 32'(rsp.found_handle),
                                    32'(oldest_answer.found_handle));
                if (rsp.slot !== oldest_answer.slot)
                    report_mismatch("slot", 32'(rsp.slot), 32'(oldest_answer.slot));
                if (rsp.evicted !== oldest_answer.evicted)
                    report_mismatch("evicted", 32'(rsp.evicted),
                                    32'(oldest_answer.evicted));
                if (rsp.evicted_handle !== oldest_answer.evicted_handle)
                    report_mismatch("evicted_handle", 32'(rsp.evicted_handle),
                                    32'(oldest_answer.evicted_handle));
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // Directed table. The store starts empty with all 64 lines in use. Then
        // come a two-line store to exercise replacement order, a setting of
        // zero (one line), and a setting past the top that saturates to the
        // full store.
        directed_rows = '{
            // Lookup in an empty store misses, and every field is zero.
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd0, 8'd0, 16'h0000},
              1'b1, '{1'b0, 16'h0000, 6'd0, 1'b0, 16'h0000}},
            // Inserts fill the lowest empty lines with no eviction.
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd15, 8'd255, 16'hFFFF},
              1'b1, '{1'b0, 16'h0000, 6'd0, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd0, 8'd0, 16'h0000},
              1'b1, '{1'b0, 16'h0000, 6'd1, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd15, 8'd255, 16'h0000},
              1'b1, '{1'b1, 16'hFFFF, 6'd0, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd0, 8'd0, 16'hFFFF},
              1'b1, '{1'b1, 16'h0000, 6'd1, 1'b0, 16'h0000}},
            // Inserting the same key again takes a new line. A later lookup
            // finds the lower index.
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd15, 8'd255, 16'h1234},
              1'b1, '{1'b0, 16'h0000, 6'd2, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd15, 8'd255, 16'h0000},
              1'b1, '{1'b1, 16'hFFFF, 6'd0, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd15, 8'd0, 16'h0000},
              1'b1, '{1'b0, 16'h0000, 6'd0, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd0, 8'd255, 16'h0000},
              1'b0, '0},
            // Two lines. A hit on line 0 leaves line 1 as the oldest.
            '{ROW_SETUP, 7'd2, '0, 1'b0, '0},
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd1, 8'd1, 16'hAAAA},
              1'b1, '{1'b0, 16'h0000, 6'd0, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd2, 8'd2, 16'h5555},
              1'b1, '{1'b0, 16'h0000, 6'd1, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd1, 8'd1, 16'h0000},
              1'b1, '{1'b1, 16'hAAAA, 6'd0, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd3, 8'd3, 16'h0F0F},
              1'b1, '{1'b0, 16'h0000, 6'd1, 1'b1, 16'h5555}},
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd4, 8'd4, 16'hF0F0},
              1'b1, '{1'b0, 16'h0000, 6'd0, 1'b1, 16'hAAAA}},
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd2, 8'd2, 16'h0000},
              1'b1, '{1'b0, 16'h0000, 6'd0, 1'b0, 16'h0000}},
            // A setting of zero acts as one line, so every insert after the
            // first replaces line 0.
            '{ROW_SETUP, 7'd0, '0, 1'b0, '0},
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd5, 8'd5, 16'h0001},
              1'b1, '{1'b0, 16'h0000, 6'd0, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd6, 8'd6, 16'h8000},
              1'b1, '{1'b0, 16'h0000, 6'd0, 1'b1, 16'h0001}},
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd6, 8'd6, 16'h0000},
              1'b1, '{1'b1, 16'h8000, 6'd0, 1'b0, 16'h0000}},
            // A setting of 127 saturates to the full store. The write also
            // emptied the store.
            '{ROW_SETUP, 7'd127, '0, 1'b0, '0},
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd6, 8'd6, 16'h0000},
              1'b1, '{1'b0, 16'h0000, 6'd0, 1'b0, 16'h0000}},
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd7, 8'd128, 16'h7FFF},
              1'b0, '0},
            '{ROW_BEAT, 7'd0, '{CMD_INSERT, 4'd8, 8'd127, 16'h8001},
              1'b0, '0},
            '{ROW_BEAT, 7'd0, '{CMD_LOOKUP, 4'd7, 8'd128, 16'h0000},
              1'b0, '0}
        };

        // Random phases. Small line counts make replacement frequent. The
        // full store and a single line cover the two extremes.
        phase_settings = '{7'd1, 7'd2, 7'd64, 7'd5, CFG_BITS'($urandom_range(3, 16)),
                           7'd3, CFG_BITS'($urandom_range(1, 64)), 7'd8};

        clear_lines();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_SETUP)
                write_setting(directed_rows[r].setting);
            else
                issue_beat(directed_rows[r].beat, directed_rows[r].fixed_rsp,
                           directed_rows[r].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_setting(phase_settings[p]);
            for (int b = 0; b < BEATS_PER_PHASE; b++)
                issue_beat(random_access(), 1'b0, '0);
        end

        // Let every answer come back, then watch a short tail for extra beats.
        req_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lbct_pkg.sv
hw/rtl/lbct_handle_ram.sv
hw/rtl/lbct_ctrl.sv
hw/rtl/lbct_dp.sv
hw/rtl/lru_block_cache_tags_core.sv
verif/testbench.sv
